[rtl/core/olie_pkg.sv]
package olie_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int DATA_W   = 32;
    localparam int OP_W     = 2;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 3;

    // operation codes
    localparam logic [OP_W-1:0] OP_FRONT = 2'd0;
    localparam logic [OP_W-1:0] OP_END   = 2'd1;
    localparam logic [OP_W-1:0] OP_POS   = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic ins;      // insert item accepted
        logic empty;    // read out accepted on an empty list
        logic rd_step;  // emit one element and rotate
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic cnt_zero;
        logic rd_last;
    } t_sts;

endpackage

[rtl/core/olie_ctrl.sv]
module olie_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [olie_pkg::OP_W-1:0] i_opcode,
    input  olie_pkg::t_sts    i_sts,
    output olie_pkg::t_cmd    o_cmd,
    output logic              busy
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;
    logic   is_read;

    assign busy    = (r_state == S_READ);
    assign accept  = start && !busy;
    assign is_read = (i_opcode == olie_pkg::OP_READ);

    always_comb begin
        o_cmd.ins     = accept && !is_read;
        o_cmd.empty   = accept && is_read && i_sts.cnt_zero;
        o_cmd.rd_step = (r_state == S_READ);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && is_read && !i_sts.cnt_zero) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (i_sts.rd_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/core/olie_datapath.sv]
module olie_datapath #(
    parameter int CAPACITY = olie_pkg::CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  olie_pkg::t_cmd                   i_cmd,
    input  logic [olie_pkg::OP_W-1:0]        i_opcode,
    input  logic signed [olie_pkg::DATA_W-1:0] i_value,
    input  logic [olie_pkg::POS_W-1:0]       i_position,
    output olie_pkg::t_sts                   o_sts,
    output logic                             o_strobe,
    output logic [olie_pkg::STATUS_W-1:0]    o_status,
    output logic signed [olie_pkg::DATA_W-1:0] o_element,
    output logic [CW-1:0]                    o_count,
    output logic                             o_last
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = ((CW > olie_pkg::POS_W) ? CW : olie_pkg::POS_W) + 1;

    logic [olie_pkg::DATA_W-1:0]   r_cells [CAPACITY];
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 r_rd_idx;
    logic                          r_strobe;
    logic [olie_pkg::STATUS_W-1:0] r_status;
    logic [olie_pkg::DATA_W-1:0]   r_element;
    logic [CW-1:0]                 r_out_count;
    logic                          r_last;

    logic                          full;
    logic                          ins_ok;
    logic                          do_ins;
    logic [olie_pkg::STATUS_W-1:0] ins_status;
    logic [IW-1:0]                 ins_idx;
    logic [olie_pkg::POS_W-1:0]    pos_m1;
    logic [CMPW-1:0]               pos_ext;
    logic [CMPW-1:0]               pos_lim;
    logic [CW-1:0]                 n_count;
    logic                          rd_last;

    assign full    = (r_count == CW'(CAPACITY));
    assign pos_m1  = i_position - olie_pkg::POS_W'(1);
    assign pos_ext = CMPW'(i_position);
    assign pos_lim = CMPW'(r_count) + CMPW'(1);

    // status priority: zero position, then full, then range
    always_comb begin
        ins_ok     = 1'b0;
        ins_status = olie_pkg::ST_OK;
        ins_idx    = '0;
        if (i_opcode == olie_pkg::OP_POS && i_position == '0) begin
            ins_status = olie_pkg::ST_INVALID;
        end else if (full) begin
            ins_status = olie_pkg::ST_FULL;
        end else if (i_opcode == olie_pkg::OP_POS && pos_ext > pos_lim) begin
            ins_status = olie_pkg::ST_RANGE;
        end else begin
            ins_ok = 1'b1;
            case (i_opcode)
                olie_pkg::OP_END: ins_idx = r_count[IW-1:0];
                olie_pkg::OP_POS: ins_idx = pos_m1[IW-1:0];
                default:          ins_idx = '0;
            endcase
        end
    end

    assign do_ins  = i_cmd.ins && ins_ok;
    assign n_count = do_ins ? (r_count + CW'(1)) : r_count;
    assign rd_last = ((r_rd_idx + CW'(1)) == r_count);

    // cells past the insert point shift back on insert; the cells step forward during read out
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [olie_pkg::DATA_W-1:0] w_prev;
        logic [olie_pkg::DATA_W-1:0] w_next;

        if (i == 0) begin : g_first
            assign w_prev = r_cells[0];
        end else begin : g_mid
            assign w_prev = r_cells[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign w_next = r_cells[0];
        end else begin : g_notlast
            assign w_next = r_cells[i+1];
        end

        always_ff @(posedge i_clk) begin
            if (do_ins) begin
                if (IW'(i) == ins_idx) begin
                    r_cells[i] <= i_value;
                end else if (IW'(i) > ins_idx) begin
                    r_cells[i] <= w_prev;
                end
            end else if (i_cmd.rd_step) begin
                if (CW'(i + 1) == r_count) begin
                    r_cells[i] <= r_cells[0];
                end else begin
                    r_cells[i] <= w_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_idx <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_rd_idx <= i_cmd.rd_step ? (r_rd_idx + CW'(1)) : '0;
            r_strobe <= i_cmd.ins || i_cmd.empty || i_cmd.rd_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_step) begin
            r_status    <= olie_pkg::ST_OK;
            r_element   <= r_cells[0];
            r_out_count <= r_count;
            r_last      <= rd_last;
        end else if (i_cmd.empty) begin
            r_status    <= olie_pkg::ST_EMPTY;
            r_element   <= '0;
            r_out_count <= r_count;
            r_last      <= 1'b1;
        end else if (i_cmd.ins) begin
            r_status    <= ins_status;
            r_element   <= '0;
            r_out_count <= n_count;
            r_last      <= 1'b1;
        end
    end

    always_comb begin
        o_sts.cnt_zero = (r_count == '0);
        o_sts.rd_last  = rd_last;
    end

    assign o_strobe  = r_strobe;
    assign o_status  = r_status;
    assign o_element = r_element;
    assign o_count   = r_out_count;
    assign o_last    = r_last;

endmodule

[rtl/core/ordered_list_insert_engine_core.sv]
// ordered list insert engine
// keeps an ordered list of up to CAPACITY signed 32-bit values
// command channel: an item (i_opcode, i_value, i_position) is taken at a
//   rising edge where start is high and busy is low
// opcodes: insert front, insert end, insert at 1-based position, read out
// result channel: o_strobe marks each result for one cycle; the receiver
//   cannot stall, so every strobed result is taken at the end of its cycle
// insert: one result (status, count after the insert, last set) in the cycle
//   after the item; busy stays low, so a new item may follow every cycle
// read out: count results, one per cycle, the final one with o_last set; the
//   item is registered into the controller state, then each element into the
//   result register; busy stays high while streaming, tying up the command channel
// empty read out: a single result with empty status, in the cycle after the item
// inserts move all cells behind the insert point back by one in parallel;
//   read out rotates the occupied cells so cell zero always holds the next
//   element, and the list is back in order when streaming ends
// reset (synchronous, active low) empties the list and drops any read out
//   in progress; cell contents are not cleared
module ordered_list_insert_engine_core #(
    parameter int CAPACITY = olie_pkg::CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [olie_pkg::OP_W-1:0]          i_opcode,
    input  logic signed [olie_pkg::DATA_W-1:0] i_value,
    input  logic [olie_pkg::POS_W-1:0]         i_position,
    output logic                               o_strobe,
    output logic [olie_pkg::STATUS_W-1:0]      o_status,
    output logic signed [olie_pkg::DATA_W-1:0] o_element,
    output logic [CW-1:0]                      o_count,
    output logic                               o_last
);

    // command and status between controller and datapath
    olie_pkg::t_cmd cmd;
    olie_pkg::t_sts sts;

    // sequencing: accept, read out streaming
    olie_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // cell array, count, insert checks and result register
    olie_datapath #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_opcode   (i_opcode),
        .i_value    (i_value),
        .i_position (i_position),
        .o_sts      (sts),
        .o_strobe   (o_strobe),
        .o_status   (o_status),
        .o_element  (o_element),
        .o_count    (o_count),
        .o_last     (o_last)
    );

endmodule

[dv/list_result_checker.sv]
module list_result_checker #(
    parameter int CAPACITY = olie_pkg::CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [olie_pkg::OP_W-1:0]           i_opcode,
    input  logic signed [olie_pkg::DATA_W-1:0]  i_value,
    input  logic [olie_pkg::POS_W-1:0]          i_position,
    input  logic                                o_strobe,
    input  logic [olie_pkg::STATUS_W-1:0]       o_status,
    input  logic signed [olie_pkg::DATA_W-1:0]  o_element,
    input  logic [CW-1:0]                       o_count,
    input  logic                                o_last,
    output int                                  fail_count,
    output int                                  results_due
);

    typedef struct {
        logic [olie_pkg::STATUS_W-1:0]      status;
        logic signed [olie_pkg::DATA_W-1:0] element;
        logic [CW-1:0]                      count;
        logic                               last;
    } t_list_result;

    t_list_result                       due_q[$];
    logic signed [olie_pkg::DATA_W-1:0] mirror_cells [CAPACITY];
    int                                 mirror_count = 0;
    int                                 mismatches = 0;

    task automatic note_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic t_list_result make_result(
        input logic [olie_pkg::STATUS_W-1:0] st,
        input logic signed [olie_pkg::DATA_W-1:0] elem,
        input logic lst);
        t_list_result r;
        r.status  = st;
        r.element = elem;
        r.count   = mirror_count[CW-1:0];
        r.last    = lst;
        return r;
    endfunction

    // update the mirrored list and queue up what the item should produce
    task automatic apply_list_op(input logic [olie_pkg::OP_W-1:0] op,
                                 input logic signed [olie_pkg::DATA_W-1:0] v,
                                 input logic [olie_pkg::POS_W-1:0] pos);
        logic                          full;
        logic [olie_pkg::STATUS_W-1:0] st;
        int                            slot;
        full = (mirror_count >= CAPACITY);
        st   = olie_pkg::ST_OK;
        slot = -1;
        if (op == olie_pkg::OP_READ) begin
            if (mirror_count == 0) begin
                due_q.push_back(make_result(olie_pkg::ST_EMPTY, '0, 1'b1));
            end else begin
                for (int i = 0; i < mirror_count; i++) begin
                    due_q.push_back(make_result(olie_pkg::ST_OK, mirror_cells[i],
                                                i == mirror_count - 1));
                end
            end
        end else begin
            case (op)
                olie_pkg::OP_FRONT: begin
                    if (full) st = olie_pkg::ST_FULL;
                    else slot = 0;
                end
                olie_pkg::OP_END: begin
                    if (full) st = olie_pkg::ST_FULL;
                    else slot = mirror_count;
                end
                default: begin
                    // zero position wins over full, full wins over range
                    if (pos == '0) st = olie_pkg::ST_INVALID;
                    else if (full) st = olie_pkg::ST_FULL;
                    else if (int'(pos) > mirror_count + 1) st = olie_pkg::ST_RANGE;
                    else slot = int'(pos) - 1;
                end
            endcase
            if (slot >= 0) begin
                for (int j = mirror_count; j > slot; j--) begin
                    mirror_cells[j] = mirror_cells[j-1];
                end
                mirror_cells[slot] = v;
                mirror_count++;
            end
            due_q.push_back(make_result(st, '0, 1'b1));
        end
    endtask

    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            due_q.delete();
            mirror_count = 0;
        end else begin
            if (o_strobe) begin
                if (due_q.size() == 0) begin
                    note_mismatch("result strobed with none due");
                end else begin
                    want = due_q.pop_front();
                    if (o_status !== want.status)
                        note_mismatch($sformatf("status %0d, want %0d",
                                                o_status, want.status));
                    if (o_element !== want.element)
                        note_mismatch($sformatf("element %0d, want %0d",
                                                o_element, want.element));
                    if (o_count !== want.count)
                        note_mismatch($sformatf("count %0d, want %0d",
                                                o_count, want.count));
                    if (o_last !== want.last)
                        note_mismatch($sformatf("last %0b, want %0b",
                                                o_last, want.last));
                end
            end
            if (start && !busy) begin
                apply_list_op(i_opcode, i_value, i_position);
            end
        end
        fail_count  <= mismatches;
        results_due <= due_q.size();
    end

endmodule

[dv/tb_ordered_list_insert_engine_core.sv]
module tb_ordered_list_insert_engine_core;

    localparam int CAP       = olie_pkg::CAPACITY_DEF;
    localparam int CW        = $clog2(CAP + 1);
    localparam int N_RANDOM  = 180;
    // worst case per item is a full read out plus the longest sender gap,
    // far below this even with the drain pauses
    localparam int MAX_CYCLES = 200000;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               start = 1'b0;
    logic                               busy;
    logic [olie_pkg::OP_W-1:0]          i_opcode = olie_pkg::OP_FRONT;
    logic signed [olie_pkg::DATA_W-1:0] i_value = '0;
    logic [olie_pkg::POS_W-1:0]         i_position = '0;
    logic                               o_strobe;
    logic [olie_pkg::STATUS_W-1:0]      o_status;
    logic signed [olie_pkg::DATA_W-1:0] o_element;
    logic [CW-1:0]                      o_count;
    logic                               o_last;

    int fail_count;
    int results_due;
    int cycles = 0;
    int burst_left = 0;

    // free-running clock, period 20
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    ordered_list_insert_engine_core #(
        .CAPACITY (CAP)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_opcode   (i_opcode),
        .i_value    (i_value),
        .i_position (i_position),
        .o_strobe   (o_strobe),
        .o_status   (o_status),
        .o_element  (o_element),
        .o_count    (o_count),
        .o_last     (o_last)
    );

    // watches both channels, mirrors the list and compares every result
    list_result_checker #(
        .CAPACITY (CAP)
    ) list_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_opcode    (i_opcode),
        .i_value     (i_value),
        .i_position  (i_position),
        .o_strobe    (o_strobe),
        .o_status    (o_status),
        .o_element   (o_element),
        .o_count     (o_count),
        .o_last      (o_last),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    // watchdog: a hung handshake or a missing result ends here
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("ordered_list_insert_engine_core regression: fail");
            $finish;
        end
    end

    // present one item and hold it until the block takes it
    // called in the time step of a rising edge; start is raised at most once
    // per step, and lowered only when a gap or a drain follows
    task automatic send_item(input logic [olie_pkg::OP_W-1:0] op,
                             input logic signed [olie_pkg::DATA_W-1:0] val,
                             input logic [olie_pkg::POS_W-1:0] pos,
                             input bit drain);
        int gap;
        start      <= 1'b1;
        i_opcode   <= op;
        i_value    <= val;
        i_position <= pos;
        // item is taken at the first edge where busy was low
        do @(posedge i_clk); while (busy);
        if (drain) begin
            // hold off until every result owed so far has come out
            start <= 1'b0;
            do @(posedge i_clk); while (results_due != 0);
        end else if (burst_left > 0) begin
            burst_left--;
        end else begin
            // end of a burst: pick the next burst length and maybe a gap
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // random value: mostly full-width noise, with the extremes mixed in
    function automatic logic signed [olie_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(olie_pkg::DATA_W-1){1'b0}}};
            1: return {1'b0, {(olie_pkg::DATA_W-1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // positions cluster around the small counts a 16-deep list can hold,
    // with zero and the far out-of-range values still common
    function automatic logic [olie_pkg::POS_W-1:0] pick_position();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return olie_pkg::POS_W'($urandom_range(1, 4));
            3, 4, 5: return olie_pkg::POS_W'($urandom_range(0, CAP + 2));
            default: return olie_pkg::POS_W'($urandom);
        endcase
    endfunction

    function automatic logic [olie_pkg::OP_W-1:0] pick_opcode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return olie_pkg::OP_FRONT;
        else if (r < 50) return olie_pkg::OP_END;
        else if (r < 85) return olie_pkg::OP_POS;
        else return olie_pkg::OP_READ;
    endfunction

    initial begin
        // hold the synchronous reset, then release it
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty read out, bad positions on an empty list
        send_item(olie_pkg::OP_READ,  32'sd7, 8'd0,   1'b0);
        send_item(olie_pkg::OP_POS,   32'sd1, 8'd0,   1'b0);  // zero position
        send_item(olie_pkg::OP_POS,   32'sd2, 8'd2,   1'b0);  // beyond range when empty
        send_item(olie_pkg::OP_POS,   32'sd3, 8'd255, 1'b0);
        // position one goes to the front
        send_item(olie_pkg::OP_POS,   32'sh7fffffff, 8'd1, 1'b0);
        send_item(olie_pkg::OP_FRONT, 32'sh80000000, 8'd0, 1'b0);
        send_item(olie_pkg::OP_END,   32'sd0,        8'hff, 1'b0);
        send_item(olie_pkg::OP_END,   -32'sd1,       8'h00, 1'b0);
        // position count+1 appends, a middle position shifts the tail
        send_item(olie_pkg::OP_POS,   32'sh55555555, 8'd5, 1'b0);
        send_item(olie_pkg::OP_POS,   32'shaaaaaaaa, 8'd3, 1'b0);
        send_item(olie_pkg::OP_READ,  32'sd0,        8'd0, 1'b0);
        // count+2 is one past the end
        send_item(olie_pkg::OP_POS,   32'sd9,        8'd8, 1'b0);
        send_item(olie_pkg::OP_POS,   32'sd10,       8'd2, 1'b0);
        send_item(olie_pkg::OP_READ,  32'sd0,        8'd0, 1'b0);
        // back to back reads, the second waits on busy
        send_item(olie_pkg::OP_READ,  32'sd0,        8'd0, 1'b1);

        // random part; the list fills after a few dozen items and then
        // exercises full against zero position and range
        for (int n = 0; n < N_RANDOM; n++) begin
            send_item(pick_opcode(), pick_value(), pick_position(),
                      n == N_RANDOM / 2 || n == N_RANDOM - 1);
        end

        // the last item drained; let any stray strobe show up
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ordered_list_insert_engine_core regression: pass");
        end else begin
            $display("ordered_list_insert_engine_core regression: fail");
        end
        $finish;
    end

endmodule
